FILE: src/cms_pkg.sv
// Package for the CoAP message serializer: opcodes, codes, constants and shared types.
package cms_pkg;

  typedef enum logic [2:0] {
    OP_HEADER    = 3'd0,
    OP_TOKEN     = 3'd1,
    OP_OPT_START = 3'd2,
    OP_OPT_BYTE  = 3'd3,
    OP_PAY_START = 3'd4,
    OP_PAY_BYTE  = 3'd5,
    OP_FINISH    = 3'd6
  } opcode_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CAPACITY = 2'd1;
  localparam logic [1:0] ERR_ORDER    = 2'd2;

  localparam logic [15:0] CAP_RESET   = 16'd1024;
  localparam logic [15:0] EXT8_OFS    = 16'd13;
  localparam logic [15:0] EXT16_OFS   = 16'd269;
  localparam logic [15:0] EXT8_MAX    = 16'hFF + 16'd13;
  localparam logic [3:0]  NIB_EXT8    = 4'd13;
  localparam logic [3:0]  NIB_EXT16   = 4'd14;
  localparam logic [7:0]  PAY_MARKER  = 8'hFF;
  localparam logic [3:0]  MAX_TOKEN   = 4'd8;
  localparam logic [2:0]  HDR_BYTES   = 3'd4;
  localparam int          MAX_BYTES   = 5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  version;
    logic [1:0]  message_type;
    logic [3:0]  token_length;
    logic [3:0]  token_supplied_length;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [15:0] value_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] prev_opt;
    logic [16:0] bytes_used;
    logic [1:0]  err;
  } enc_state_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                n;
    enc_state_t                nxt;
  } enc_result_t;

  // delta/length nibble of an option header byte
  function automatic logic [3:0] nibble_of(input logic [15:0] v);
    if (v < EXT8_OFS) begin
      return v[3:0];
    end else if (v <= EXT8_MAX) begin
      return NIB_EXT8;
    end
    return NIB_EXT16;
  endfunction

endpackage

FILE: src/coap_message_serializer.sv
// Top level of the CoAP message serializer: input handshake, byte queue and output stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | in_valid/in_stall  | opcode, header fields, option fields, byte
//  output  | out       | out_valid/out_stall| out_byte, byte_valid, status, total_length, last
//  config  | in        | wr_en              | wr_data -> buffer_capacity
//
// An input word is encoded in the cycle it is accepted; its 1..5 result words then
// leave one per cycle from a small byte queue while out_stall is low; a word with no
// bytes leaves one status-only word. Byte streams run at one word per cycle without
// stalls, and a header holds the input until its result words have left. The next input
// word is taken in the cycle the last result word of the previous one is taken.
// Reset (rst, synchronous) empties the queue, clears the message state and sets
// buffer_capacity to 1024. A stalled output holds its word and stalls the input.
module coap_message_serializer (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [1:0]  version,
  input  logic [1:0]  message_type,
  input  logic [3:0]  token_length,
  input  logic [3:0]  token_supplied_length,
  input  logic [7:0]  code,
  input  logic [15:0] message_id,
  input  logic [15:0] option_number,
  input  logic [15:0] value_length,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [1:0]  status,
  output logic [15:0] total_length,
  output logic        last,
  // configuration
  input  logic        wr_en,
  input  logic [15:0] wr_data
);

  logic [15:0]          cap;
  cms_pkg::enc_state_t  st;
  cms_pkg::item_t       item;
  cms_pkg::enc_result_t res;

  // result queue: bytes of the current word, words left, read position
  logic [cms_pkg::MAX_BYTES-1:0][7:0] qbytes;
  logic [2:0]  rem;
  logic [2:0]  pos;
  logic        qhas;
  logic [1:0]  qstatus;
  logic [15:0] qtotal;

  logic accept;
  logic pop;

  assign item = '{opcode: opcode, version: version, message_type: message_type,
                  token_length: token_length,
                  token_supplied_length: token_supplied_length,
                  code: code, message_id: message_id,
                  option_number: option_number, value_length: value_length,
                  data_byte: data_byte};

  cms_encoder u_enc (
    .cap  (cap),
    .item (item),
    .st   (st),
    .res  (res)
  );

  assign out_valid = (rem != 3'd0);
  assign pop       = out_valid && !out_stall;
  // held during reset; free when empty, or when the final word leaves in this cycle
  assign in_stall  = rst || !((rem == 3'd0) || (rem == 3'd1 && !out_stall));
  assign accept    = in_valid && !in_stall;

  assign out_byte     = qbytes[pos];
  assign byte_valid   = qhas;
  assign status       = qstatus;
  assign total_length = qtotal;
  assign last         = (rem == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= cms_pkg::CAP_RESET;
    end else if (wr_en) begin
      cap <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      rem <= '0;
      pos <= '0;
    end else if (accept) begin
      st  <= res.nxt;
      rem <= (res.n == 3'd0) ? 3'd1 : res.n;
      pos <= '0;
    end else if (pop) begin
      rem <= rem - 3'd1;
      pos <= pos + 3'd1;
    end
  end

  // payload of the queue, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      qbytes  <= res.bytes;
      qhas    <= (res.n != 3'd0);
      qstatus <= res.nxt.err;
      qtotal  <= res.nxt.bytes_used[15:0];
    end
  end

  // a taken word always produces output in the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word left no output");

  // a status-only word is a single result
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && pos == 3'd0)
    else $error("status-only result not marked last");

  // read position never runs past the queue
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, pos} + {1'b0, rem}) <= 4'(cms_pkg::MAX_BYTES))
    else $error("queue position out of range");

  // a new word enters only while the last queued word leaves or the queue is empty
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && out_valid |-> last && !out_stall)
    else $error("input taken over pending results");

endmodule

FILE: src/cms_encoder.sv
// Combinational encoder: one input word and the message state in, bytes and next state out.
module cms_encoder (
  input  logic [15:0]          cap,
  input  cms_pkg::item_t       item,
  input  cms_pkg::enc_state_t  st,
  output cms_pkg::enc_result_t res
);

  logic [15:0] delta;
  logic [3:0]  dn;
  logic [3:0]  ln;
  logic [15:0] d16;
  logic [15:0] l16;
  logic [2:0]  dext;
  logic [2:0]  lext;
  logic [2:0]  opt_n;
  logic [2:0]  lpos;
  logic [cms_pkg::MAX_BYTES-1:0][7:0] opt_bytes;
  logic [17:0] cap18;
  logic [17:0] opt_need;
  logic [17:0] pay_need;
  logic [17:0] one_need;
  logic [4:0]  hdr_need;

  assign delta = item.option_number - st.prev_opt;
  assign dn    = cms_pkg::nibble_of(delta);
  assign ln    = cms_pkg::nibble_of(item.value_length);
  assign d16   = delta - cms_pkg::EXT16_OFS;
  assign l16   = item.value_length - cms_pkg::EXT16_OFS;
  assign dext  = (dn == cms_pkg::NIB_EXT8) ? 3'd1 : (dn == cms_pkg::NIB_EXT16) ? 3'd2 : 3'd0;
  assign lext  = (ln == cms_pkg::NIB_EXT8) ? 3'd1 : (ln == cms_pkg::NIB_EXT16) ? 3'd2 : 3'd0;
  assign opt_n = 3'd1 + dext + lext;
  assign lpos  = 3'd1 + dext;

  assign cap18    = {2'b00, cap};
  assign opt_need = {1'b0, st.bytes_used} + {15'd0, opt_n} + {2'b00, item.value_length};
  assign pay_need = {1'b0, st.bytes_used} + 18'd1 + {2'b00, item.value_length};
  assign one_need = {1'b0, st.bytes_used} + 18'd1;
  assign hdr_need = {1'b0, item.token_length} + {2'b00, cms_pkg::HDR_BYTES};

  always_comb begin
    opt_bytes = '0;
    opt_bytes[0] = {dn, ln};
    if (dn == cms_pkg::NIB_EXT8) begin
      opt_bytes[1] = delta[7:0] - cms_pkg::EXT8_OFS[7:0];
    end else if (dn == cms_pkg::NIB_EXT16) begin
      opt_bytes[1] = d16[15:8];
      opt_bytes[2] = d16[7:0];
    end
    if (ln == cms_pkg::NIB_EXT8) begin
      opt_bytes[lpos] = item.value_length[7:0] - cms_pkg::EXT8_OFS[7:0];
    end else if (ln == cms_pkg::NIB_EXT16) begin
      opt_bytes[lpos]        = l16[15:8];
      opt_bytes[lpos + 3'd1] = l16[7:0];
    end
  end

  always_comb begin
    res       = '0;
    res.nxt   = st;
    if (cms_pkg::opcode_t'(item.opcode) == cms_pkg::OP_HEADER) begin
      res.nxt.err      = cms_pkg::ERR_NONE;
      res.nxt.prev_opt = '0;
      if ({11'd0, hdr_need} > cap) begin
        res.nxt.err = cms_pkg::ERR_CAPACITY;
      end else if (item.token_length > cms_pkg::MAX_TOKEN ||
                   (item.token_length != 4'd0 &&
                    item.token_length != item.token_supplied_length)) begin
        res.nxt.err = cms_pkg::ERR_ORDER;
      end else begin
        res.bytes[0] = {item.version, item.message_type, item.token_length};
        res.bytes[1] = item.code;
        res.bytes[2] = item.message_id[15:8];
        res.bytes[3] = item.message_id[7:0];
        res.n        = cms_pkg::HDR_BYTES;
      end
      res.nxt.bytes_used = {14'd0, res.n};
    end else if (st.err == cms_pkg::ERR_NONE) begin
      case (cms_pkg::opcode_t'(item.opcode))
        cms_pkg::OP_TOKEN, cms_pkg::OP_OPT_BYTE, cms_pkg::OP_PAY_BYTE: begin
          if (one_need > cap18) begin
            res.nxt.err = cms_pkg::ERR_CAPACITY;
          end else begin
            res.bytes[0] = item.data_byte;
            res.n        = 3'd1;
          end
        end
        cms_pkg::OP_OPT_START: begin
          if (item.option_number < st.prev_opt) begin
            res.nxt.err = cms_pkg::ERR_ORDER;
          end else if (opt_need > cap18) begin
            res.nxt.err = cms_pkg::ERR_CAPACITY;
          end else begin
            res.bytes        = opt_bytes;
            res.n            = opt_n;
            res.nxt.prev_opt = item.option_number;
          end
        end
        cms_pkg::OP_PAY_START: begin
          if (item.value_length != 16'd0) begin
            if (pay_need > cap18) begin
              res.nxt.err = cms_pkg::ERR_CAPACITY;
            end else begin
              res.bytes[0] = cms_pkg::PAY_MARKER;
              res.n        = 3'd1;
            end
          end
        end
        default: begin
          // finish and the unused code: status only
        end
      endcase
      res.nxt.bytes_used = st.bytes_used + {14'd0, res.n};
    end
  end

endmodule

FILE: dv/coap_message_serializer_tb.sv
// Self-checking testbench for coap_message_serializer: directed and random CoAP messages.
module coap_message_serializer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no word moving on either channel before the run is declared hung.
  // The receiver hold-off below is far shorter than this.
  localparam int QUIET_LIMIT = 2000;
  // Receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  // Extra cycles after the last expected word before a config write or the end.
  localparam int DRAIN_GAP   = 8;
  // Random words per idling phase.
  localparam int PHASE_WORDS = 56;

  // One word seen on the output channel.
  typedef struct {
    logic [7:0]  octet;
    logic        has_byte;
    logic [1:0]  status;
    logic [15:0] length;
    logic        last;
  } coap_out_t;

  // Encoder state mirror plus the queue of output words still owed by the block.
  class coap_byte_checker;
    int unsigned capacity;
    logic [15:0] prev_opt;
    int unsigned used;
    logic [1:0]  err;
    logic [7:0]  enc[$];
    coap_out_t   pending_bytes[$];
    int          mismatches;

    function new();
      capacity   = 32'(cms_pkg::CAP_RESET);
      prev_opt   = '0;
      used       = 0;
      err        = cms_pkg::ERR_NONE;
      mismatches = 0;
    endfunction

    // 4-bit delta/length field of an option byte
    function logic [3:0] opt_nibble(input int unsigned v);
      if (v < 32'(cms_pkg::EXT8_OFS)) return v[3:0];
      if (v <= 32'(cms_pkg::EXT8_MAX)) return cms_pkg::NIB_EXT8;
      return cms_pkg::NIB_EXT16;
    endfunction

    // extension bytes that follow the option byte for one nibble
    function void push_ext(input logic [3:0] nib, input int unsigned v);
      logic [15:0] wide;
      wide = 16'(v - 32'(cms_pkg::EXT16_OFS));
      if (nib == cms_pkg::NIB_EXT8) begin
        enc.push_back(8'(v - 32'(cms_pkg::EXT8_OFS)));
      end else if (nib == cms_pkg::NIB_EXT16) begin
        enc.push_back(wide[15:8]);
        enc.push_back(wide[7:0]);
      end
    endfunction

    // Encode one accepted input word and queue the output words it owes.
    function void predict_word(input cms_pkg::item_t w);
      int unsigned onum;
      int unsigned vlen;
      int unsigned tkl;
      int unsigned delta;
      logic [3:0]  dn;
      logic [3:0]  ln;
      coap_out_t   r;
      enc.delete();
      onum = 32'(w.option_number);
      vlen = 32'(w.value_length);
      tkl  = 32'(w.token_length);
      if (cms_pkg::opcode_t'(w.opcode) == cms_pkg::OP_HEADER) begin
        // a header restarts the message and clears a sticky error
        err      = cms_pkg::ERR_NONE;
        prev_opt = '0;
        used     = 0;
        if (4 + tkl > capacity) begin
          err = cms_pkg::ERR_CAPACITY;
        end else if (tkl > 32'(cms_pkg::MAX_TOKEN) ||
                     (tkl != 0 && w.token_length != w.token_supplied_length)) begin
          err = cms_pkg::ERR_ORDER;
        end else begin
          enc.push_back({w.version, w.message_type, w.token_length});
          enc.push_back(w.code);
          enc.push_back(w.message_id[15:8]);
          enc.push_back(w.message_id[7:0]);
        end
      end else if (err == cms_pkg::ERR_NONE) begin
        case (cms_pkg::opcode_t'(w.opcode))
          cms_pkg::OP_TOKEN, cms_pkg::OP_OPT_BYTE, cms_pkg::OP_PAY_BYTE: begin
            enc.push_back(w.data_byte);
          end
          cms_pkg::OP_OPT_START: begin
            if (w.option_number < prev_opt) begin
              err = cms_pkg::ERR_ORDER;
            end else begin
              delta = onum - 32'(prev_opt);
              dn = opt_nibble(delta);
              ln = opt_nibble(vlen);
              enc.push_back({dn, ln});
              push_ext(dn, delta);
              push_ext(ln, vlen);
              // the declared value length has to fit too
              if (used + 32'(enc.size()) + vlen > capacity) begin
                err = cms_pkg::ERR_CAPACITY;
                enc.delete();
              end else begin
                prev_opt = w.option_number;
              end
            end
          end
          cms_pkg::OP_PAY_START: begin
            // empty payload: no marker at all
            if (vlen > 0) begin
              if (used + 1 + vlen > capacity) err = cms_pkg::ERR_CAPACITY;
              else enc.push_back(cms_pkg::PAY_MARKER);
            end
          end
          default: ;
        endcase
        if (enc.size() > 0 && used + 32'(enc.size()) > capacity) begin
          err = cms_pkg::ERR_CAPACITY;
          enc.delete();
        end
      end
      used += 32'(enc.size());
      r.status = err;
      r.length = 16'(used);
      if (enc.size() == 0) begin
        r.octet    = 8'h00;
        r.has_byte = 1'b0;
        r.last     = 1'b1;
        pending_bytes.push_back(r);
      end else begin
        foreach (enc[i]) begin
          r.octet    = enc[i];
          r.has_byte = 1'b1;
          r.last     = (i == enc.size() - 1);
          pending_bytes.push_back(r);
        end
      end
    endfunction

    task report(input string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_word(input coap_out_t got);
      coap_out_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected word byte=%02h valid=%0b status=%0d len=%0d last=%0b",
                         got.octet, got.has_byte, got.status, got.length, got.last));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.octet !== want.octet)
        report($sformatf("out_byte %02h, want %02h", got.octet, want.octet));
      if (got.has_byte !== want.has_byte)
        report($sformatf("byte_valid %0b, want %0b", got.has_byte, want.has_byte));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.length !== want.length)
        report($sformatf("total_length %0d, want %0d", got.length, want.length));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic           clk;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  cms_pkg::item_t drv       = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [7:0]     out_byte;
  logic           byte_valid;
  logic [1:0]     status;
  logic [15:0]    total_length;
  logic           last;
  logic           wr_en     = 1'b0;
  logic [15:0]    wr_data   = '0;

  coap_byte_checker enc_sb;
  int send_idle_pct = 0;   // chance in 100 that the sender idles a cycle
  int recv_idle_pct = 0;   // chance in 100 that the receiver stalls a cycle
  int items_sent    = 0;
  logic hold_req    = 1'b0;  // raised once by the stimulus
  logic hold_taken  = 1'b0;  // hold-off already started
  int hold_left     = 0;
  int quiet_cycles  = 0;
  coap_out_t seen;

  coap_message_serializer dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .opcode                (drv.opcode),
    .version               (drv.version),
    .message_type          (drv.message_type),
    .token_length          (drv.token_length),
    .token_supplied_length (drv.token_supplied_length),
    .code                  (drv.code),
    .message_id            (drv.message_id),
    .option_number         (drv.option_number),
    .value_length          (drv.value_length),
    .data_byte             (drv.data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte              (out_byte),
    .byte_valid            (byte_valid),
    .status                (status),
    .total_length          (total_length),
    .last                  (last),
    .wr_en                 (wr_en),
    .wr_data               (wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Output side: check every word taken, then pick next cycle's stall.
  // A hold request pins stall high for HOLD_CYCLES, counted here.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen.octet    = out_byte;
      seen.has_byte = byte_valid;
      seen.status   = status;
      seen.length   = total_length;
      seen.last     = last;
      enc_sb.check_word(seen);
    end
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Hang detector: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Random content in every field; the opcode is the caller's.
  function automatic cms_pkg::item_t rand_word(input logic [2:0] op);
    cms_pkg::item_t w;
    w.opcode                = op;
    w.version               = 2'($urandom_range(3));
    w.message_type          = 2'($urandom_range(3));
    w.token_length          = 4'($urandom_range(8));
    w.token_supplied_length = 4'($urandom_range(8));
    w.code                  = 8'($urandom_range(255));
    w.message_id            = 16'($urandom_range(65535));
    w.option_number         = 16'($urandom_range(65535));
    w.value_length          = 16'($urandom_range(65535));
    w.data_byte             = 8'($urandom_range(255));
    return w;
  endfunction

  // Offer one input word and return at the edge it is taken. Valid stays high
  // afterwards so back-to-back words need no extra edge; whoever comes next
  // either drives a new word or lowers valid.
  task automatic send_word(input cms_pkg::item_t w);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    drv      <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    enc_sb.predict_word(w);
    items_sent++;
  endtask

  task automatic send_header(input logic [1:0] ver, input logic [1:0] typ,
                             input logic [3:0] tkl, input logic [3:0] tsup,
                             input logic [7:0] cd, input logic [15:0] mid);
    cms_pkg::item_t w;
    w = rand_word(cms_pkg::OP_HEADER);
    w.version               = ver;
    w.message_type          = typ;
    w.token_length          = tkl;
    w.token_supplied_length = tsup;
    w.code                  = cd;
    w.message_id            = mid;
    send_word(w);
  endtask

  task automatic send_option(input logic [15:0] onum, input logic [15:0] vlen);
    cms_pkg::item_t w;
    w = rand_word(cms_pkg::OP_OPT_START);
    w.option_number = onum;
    w.value_length  = vlen;
    send_word(w);
  endtask

  task automatic send_pay_start(input logic [15:0] vlen);
    cms_pkg::item_t w;
    w = rand_word(cms_pkg::OP_PAY_START);
    w.value_length = vlen;
    send_word(w);
  endtask

  task automatic send_byte(input cms_pkg::opcode_t op, input logic [7:0] d);
    cms_pkg::item_t w;
    w = rand_word(op);
    w.data_byte = d;
    send_word(w);
  endtask

  // Drop valid and wait until every owed output word has been taken, then let
  // the block settle before anything touches the config register.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (enc_sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_capacity(input logic [15:0] v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    enc_sb.capacity = 32'(v);
  endtask

  // One mostly well-formed message: header, token, ascending options with
  // values, optional payload, finish. A few backwards options, token length
  // mismatches and oversized value lengths are mixed in.
  task automatic send_message();
    int unsigned tkl;
    int unsigned tsup;
    int unsigned opt_no;
    int unsigned nxt;
    int unsigned vlen;
    int unsigned kind;
    int unsigned nbytes;
    tkl  = $urandom_range(8);
    tsup = ($urandom_range(7) == 0) ? $urandom_range(8) : tkl;
    send_header(2'($urandom_range(3)), 2'($urandom_range(3)), 4'(tkl), 4'(tsup),
                8'($urandom_range(255)), 16'($urandom_range(65535)));
    repeat (tkl) send_byte(cms_pkg::OP_TOKEN, 8'($urandom_range(255)));
    opt_no = 0;
    repeat ($urandom_range(3)) begin
      kind = $urandom_range(19);
      if (kind == 0 && opt_no > 0) nxt = $urandom_range(opt_no - 1);      // goes backwards
      else if (kind < 12) nxt = opt_no + $urandom_range(12);              // short delta
      else if (kind < 16) nxt = opt_no + $urandom_range(268, 13);         // 8-bit extension
      else if (kind < 19) nxt = opt_no + $urandom_range(2000, 269);       // 16-bit extension
      else nxt = $urandom_range(65535, opt_no);
      if (nxt > 65535) nxt = 65535;
      kind   = $urandom_range(9);
      nbytes = 0;
      if (kind < 7) begin
        vlen   = $urandom_range(4);
        nbytes = vlen;
      end else if (kind == 7) vlen = $urandom_range(268, 13);
      else if (kind == 8) vlen = $urandom_range(2000, 269);
      else vlen = $urandom_range(65535);
      send_option(16'(nxt), 16'(vlen));
      if (nxt >= opt_no) opt_no = nxt;
      repeat (nbytes) send_byte(cms_pkg::OP_OPT_BYTE, 8'($urandom_range(255)));
    end
    if ($urandom_range(4) > 1) begin
      vlen = $urandom_range(6);
      send_pay_start(16'(vlen));
      repeat (vlen) send_byte(cms_pkg::OP_PAY_BYTE, 8'($urandom_range(255)));
    end
    send_word(rand_word(cms_pkg::OP_FINISH));
  endtask

  // Random part of one phase: messages with about one stray word in ten.
  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(9) == 0) send_word(rand_word(3'($urandom_range(6))));
      else send_message();
    end
  endtask

  initial begin
    enc_sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, widest capacity ----
    send_idle_pct = 36;
    recv_idle_pct = 80;
    set_capacity(16'hFFFF);
    send_header(2'd3, 2'd3, 4'd8, 4'd8, 8'hFF, 16'hFFFF);   // all header fields at max
    send_byte(cms_pkg::OP_TOKEN, 8'h00);
    send_byte(cms_pkg::OP_TOKEN, 8'hFF);
    send_option(16'd0, 16'd0);                 // zero delta, zero length
    send_option(16'd12, 16'd12);               // largest inline nibbles
    send_byte(cms_pkg::OP_OPT_BYTE, 8'hA5);
    send_option(16'd25, 16'd268);              // delta 13, length at 8-bit extension top
    send_option(16'd293, 16'd269);             // delta 268, length needs 16-bit extension
    send_option(16'd562, 16'd0);               // delta 269: smallest 16-bit extension
    send_option(16'hFFFF, 16'd1000);           // five bytes from one word
    send_option(16'd100, 16'd0);               // option number goes backwards
    send_byte(cms_pkg::OP_TOKEN, 8'h5A);       // swallowed by the sticky error
    send_word(rand_word(cms_pkg::OP_FINISH));
    send_header(2'd0, 2'd0, 4'd0, 4'd5, 8'h00, 16'h0000);   // empty token ignores supplied length
    send_pay_start(16'd0);                     // empty payload: no marker
    send_pay_start(16'hFFFF);                  // payload does not fit
    send_header(2'd1, 2'd2, 4'd3, 4'd4, 8'h01, 16'h0001);   // token length mismatch
    send_header(2'd1, 2'd0, 4'd2, 4'd2, 8'h45, 16'h1234);
    send_option(16'hFFFF, 16'hFFFF);           // declared value overflows capacity
    send_header(2'd1, 2'd1, 4'd0, 4'd0, 8'h02, 16'h00FF);
    send_pay_start(16'd5);
    send_word(rand_word(cms_pkg::OP_FINISH));

    // ---- directed part, smallest capacity ----
    wait_drained();
    set_capacity(16'd4);
    send_header(2'd1, 2'd0, 4'd1, 4'd1, 8'h01, 16'h0102);   // header plus token too long
    send_header(2'd1, 2'd0, 4'd0, 4'd0, 8'h01, 16'h0102);   // exactly fills the buffer
    send_byte(cms_pkg::OP_PAY_BYTE, 8'h33);    // no room left
    send_option(16'd0, 16'd0);

    // ---- random: sender idles often, receiver stalls most cycles ----
    wait_drained();
    set_capacity(cms_pkg::CAP_RESET);
    run_random(PHASE_WORDS);

    // ---- random: roles swapped, tight buffer so capacity errors show up ----
    wait_drained();
    set_capacity(16'($urandom_range(48, 4)));
    send_idle_pct = 80;
    recv_idle_pct = 36;
    run_random(PHASE_WORDS);

    // ---- random: no idling; long receiver hold-off first to back up the input ----
    wait_drained();
    set_capacity(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(PHASE_WORDS / 2);
    wait_drained();                            // sender waits for every owed word
    run_random(PHASE_WORDS / 2);

    wait_drained();
    if (enc_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cms_pkg.sv
src/cms_encoder.sv
src/coap_message_serializer.sv
dv/coap_message_serializer_tb.sv
